>>> design/r2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2p_pkg: shared types and tables for the RGB to palette index unit
// Holds the pipeline item type, the dither offset tables and the ramp tables.
// ----------------------------------------------------------------------------
package r2p_pkg;

	// Pixel as packed in the input tdata: red in the lowest byte.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// Position in the ten-entry noise table (0 means no noise).
	typedef logic [3:0] noise_sel_t;

	typedef logic signed [5:0] cube_off_t;
	typedef logic signed [3:0] ramp_off_t;

	// One pixel with the noise entries drawn for it.
	typedef struct packed {
		pixel_t     pixel;
		noise_sel_t noise_r;
		noise_sel_t noise_g;
		noise_sel_t noise_b;
	} item_t;

	localparam noise_sel_t NOISE_NONE = 4'd0;

	// floor(tenths * 51 / 10) for each table entry
	function automatic cube_off_t cube_offset(input noise_sel_t sel);
		cube_off_t off;
		unique case (sel)
			4'd0:    off = 6'sd0;
			4'd1:    off = 6'sd5;
			4'd2:    off = -6'sd21;
			4'd3:    off = 6'sd10;
			4'd4:    off = -6'sd16;
			4'd5:    off = 6'sd15;
			4'd6:    off = -6'sd11;
			4'd7:    off = 6'sd20;
			4'd8:    off = -6'sd6;
			4'd9:    off = 6'sd25;
			default: off = 6'sd0;
		endcase
		return off;
	endfunction

	// floor(tenths * 8 / 10) for each table entry
	function automatic ramp_off_t ramp_offset(input noise_sel_t sel);
		ramp_off_t off;
		unique case (sel)
			4'd0:    off = 4'sd0;
			4'd1:    off = 4'sd0;
			4'd2:    off = -4'sd4;
			4'd3:    off = 4'sd1;
			4'd4:    off = -4'sd3;
			4'd5:    off = 4'sd2;
			4'd6:    off = -4'sd2;
			4'd7:    off = 4'sd3;
			4'd8:    off = -4'sd1;
			4'd9:    off = 4'sd4;
			default: off = 4'sd0;
		endcase
		return off;
	endfunction

	localparam logic [7:0] RAMP_RED [16] = '{
		8'd0, 8'd216, 8'd217, 8'd1, 8'd218, 8'd219, 8'd2, 8'd220,
		8'd221, 8'd3, 8'd222, 8'd223, 8'd4, 8'd224, 8'd225, 8'd5};
	localparam logic [7:0] RAMP_GREEN [16] = '{
		8'd0, 8'd226, 8'd227, 8'd6, 8'd228, 8'd229, 8'd12, 8'd230,
		8'd231, 8'd18, 8'd232, 8'd233, 8'd24, 8'd234, 8'd235, 8'd30};
	localparam logic [7:0] RAMP_BLUE [16] = '{
		8'd0, 8'd236, 8'd237, 8'd36, 8'd238, 8'd239, 8'd72, 8'd240,
		8'd241, 8'd108, 8'd242, 8'd243, 8'd144, 8'd244, 8'd245, 8'd180};
	localparam logic [7:0] RAMP_GREY [16] = '{
		8'd0, 8'd246, 8'd247, 8'd43, 8'd248, 8'd249, 8'd86, 8'd250,
		8'd251, 8'd129, 8'd252, 8'd253, 8'd172, 8'd254, 8'd255, 8'd215};

endpackage
`default_nettype wire

>>> design/r2p_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2p_map: pixel to palette index mapping
// Adds the dither offsets with clamping, quantizes to six levels and picks
// the cube entry or one of the four ramps.
// ----------------------------------------------------------------------------
module r2p_map
	import r2p_pkg::*;
(
	input  item_t      item,
	output logic [7:0] color_index
);

	// Clamp v + off to 0..255.
	function automatic logic [7:0] add_clamp(input logic [7:0] v, input cube_off_t off);
		logic signed [9:0] s;
		s = signed'({2'b00, v}) + 10'(off);
		if (s < 10'sd0)
			return 8'd0;
		else if (s > 10'sd255)
			return 8'd255;
		else
			return s[7:0];
	endfunction

	// (v + 26) / 51 as a count of thresholds passed
	function automatic logic [2:0] level6(input logic [7:0] v);
		return 3'(v >= 8'd25) + 3'(v >= 8'd76) + 3'(v >= 8'd127)
			+ 3'(v >= 8'd178) + 3'(v >= 8'd229);
	endfunction

	logic [7:0] cr, cg, cb;
	logic [7:0] fr, fg, fb;
	logic [2:0] qr, qg, qb;
	logic [9:0] grey_sum;
	logic [3:0] grey_sel;
	logic [7:0] cube_idx;

	always_comb begin
		cr = add_clamp(item.pixel.red,   cube_offset(item.noise_r));
		cg = add_clamp(item.pixel.green, cube_offset(item.noise_g));
		cb = add_clamp(item.pixel.blue,  cube_offset(item.noise_b));
		fr = add_clamp(item.pixel.red,   6'(ramp_offset(item.noise_r)));
		fg = add_clamp(item.pixel.green, 6'(ramp_offset(item.noise_g)));
		fb = add_clamp(item.pixel.blue,  6'(ramp_offset(item.noise_b)));
		qr = level6(cr);
		qg = level6(cg);
		qb = level6(cb);
	end

	// floor(sum / 48) by threshold count; the sum never exceeds 765
	always_comb begin
		grey_sum = 10'(fr) + 10'(fg) + 10'(fb);
		grey_sel = 4'd0;
		for (int k = 1; k < 16; k++) begin
			if (grey_sum >= 10'(48 * k))
				grey_sel = grey_sel + 4'd1;
		end
	end

	assign cube_idx = 8'(qr) + 8'(qg) * 8'd6 + 8'(qb) * 8'd36;

	always_comb begin
		if (qr == qg) begin
			if (qr == qb)
				color_index = RAMP_GREY[grey_sel];
			else if (qr == 3'd0)
				color_index = RAMP_BLUE[fb[7:4]];
			else
				color_index = cube_idx;
		end else if (qg == 3'd0 && qb == 3'd0) begin
			color_index = RAMP_RED[fr[7:4]];
		end else if (qr == 3'd0 && qb == 3'd0) begin
			color_index = RAMP_GREEN[fg[7:4]];
		end else begin
			color_index = cube_idx;
		end
	end

endmodule
`default_nettype wire

>>> design/rgb24_to_palette_index_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb24_to_palette_index_unit: 24-bit RGB pixel to 8-bit palette index
// Maps each pixel to the 6x6x6 color cube or to a red, green, blue or grey
// ramp, with optional cyclic table dither.
//
//   channel   direction  payload                         transfer when
//   s_axis    in         tdata[23:0] red, green, blue    tvalid & tready
//   m_axis    out        tdata[7:0]  color_index         tvalid & tready
//   cfg       in         cfg_wdata   dither_enable       cfg_we
//
// One pixel per cycle sustained while m_axis does not stall; the path from input
// transfer to output is an input register, then the mapping logic into the output register.
// The noise cursor steps three draws at each dithered input transfer, so it never
// limits the rate.
// Reset clears the valid flags, the dither enable and the noise cursor.
// A stall on m_axis holds the output register; the input register keeps
// accepting until it too is full, then tready drops.
// ----------------------------------------------------------------------------
module rgb24_to_palette_index_unit
	import r2p_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,      // dither_enable
	// pixel input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	// palette index output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata    // [7:0] color_index
);

	// Cursor state that draws table entry 0 and wraps to the start.
	localparam noise_sel_t NOISE_WRAP = 4'd10;

	function automatic noise_sel_t pos_next(input noise_sel_t p);
		return (p >= NOISE_WRAP) ? 4'd0 : p + 4'd1;
	endfunction

	function automatic noise_sel_t pos_entry(input noise_sel_t p);
		return (p >= NOISE_WRAP) ? NOISE_NONE : p;
	endfunction

	logic       dither_enable_q;
	noise_sel_t noise_position_q;

	item_t      item_s1;
	logic       valid_s1;
	logic [7:0] index_s2;
	logic       valid_s2;

	logic       s_accept;
	logic       adv_s2;
	noise_sel_t pos1, pos2, pos3;
	item_t      item_in;
	logic [7:0] index_comb;

	// Output register may load when empty or when its content is taken.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Three draws per dithered pixel, in order red, green, blue.
	always_comb begin
		pos1  = pos_next(noise_position_q);
		pos2  = pos_next(pos1);
		pos3  = pos_next(pos2);
		item_in.pixel = pixel_t'(s_axis_tdata);
		if (dither_enable_q) begin
			item_in.noise_r = pos_entry(noise_position_q);
			item_in.noise_g = pos_entry(pos1);
			item_in.noise_b = pos_entry(pos2);
		end else begin
			item_in.noise_r = NOISE_NONE;
			item_in.noise_g = NOISE_NONE;
			item_in.noise_b = NOISE_NONE;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_enable_q <= 1'b0;
		end else if (cfg_we) begin
			dither_enable_q <= cfg_wdata;
		end
	end

	// Noise cursor: advance only on dithered transfers, hold otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_position_q <= 4'd0;
		end else if (s_accept && dither_enable_q) begin
			noise_position_q <= pos3;
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= item_in;
		end
	end

	r2p_map u_map (
		.item        (item_s1),
		.color_index (index_comb)
	);

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			index_s2 <= index_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = index_s2;

	// Cursor stays within its eleven states.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		noise_position_q <= NOISE_WRAP)
		else $error("noise cursor out of range");

	// Direct mode never moves the cursor.
	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!dither_enable_q |=> noise_position_q == $past(noise_position_q))
		else $error("noise cursor moved in direct mode");

	// A direct-mode pixel carries no noise.
	a_direct_no_noise: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !dither_enable_q) |=>
			(item_s1.noise_r == NOISE_NONE && item_s1.noise_g == NOISE_NONE
			&& item_s1.noise_b == NOISE_NONE))
		else $error("noise applied in direct mode");

	// Both stages full and output stalled: input must back off.
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while pipeline full");

endmodule
`default_nettype wire
